### hw/rtl/rgb565_downsample_pack_macros.svh
// assertion macros shared by the rgb565 downsample packer
`ifndef RGB565_DOWNSAMPLE_PACK_MACROS_SVH
`define RGB565_DOWNSAMPLE_PACK_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define RDP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define RDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rdp_pkg.sv
// shared constants and types of the rgb565 downsample packer
package rdp_pkg;

   localparam int SRC_WIDTH  = 320;
   localparam int SRC_HEIGHT = 240;

   localparam int PIXEL_W   = 16;
   localparam int BYTE_W    = 8;
   localparam int CFG_W     = 8;
   localparam int SRC_COL_W = 9;
   localparam int SRC_ROW_W = 8;
   localparam int DST_COL_W = 8;
   localparam int DST_ROW_W = 7;
   localparam int CNT_W     = 3;

   localparam logic [CFG_W-1:0] TARGET_MONO  = 8'd1;
   localparam logic [CFG_W-1:0] TARGET_GRAY2 = 8'd2;
   localparam logic [CFG_W-1:0] TARGET_RESET = TARGET_MONO;

   localparam int MONO_DW  = 128;
   localparam int MONO_DH  = 64;
   localparam int GRAY2_DW = 240;
   localparam int GRAY2_DH = 128;
   localparam int MONO_PPB  = 8;
   localparam int GRAY2_PPB = 4;

   localparam int MONO_COL_SHIFT  = $clog2(MONO_DW);
   localparam int MONO_ROW_SHIFT  = $clog2(MONO_DH);
   localparam int GRAY2_ROW_SHIFT = $clog2(GRAY2_DH);

   // reciprocal of the gray2 column step: floor(x*SRC_WIDTH/240) = (x*COL_RECIP) >> shift
   localparam int COL_RECIP_SHIFT = 20;
   localparam int COL_RECIP = (SRC_WIDTH * (1 << COL_RECIP_SHIFT) + GRAY2_DW - 1) / GRAY2_DW;
   localparam int COL_RECIP_W = 22;

   localparam logic [7:0] MONO_THRESHOLD = 8'd128;

   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic              frame_last;
   } rsp_item_type;

endpackage

### hw/rtl/rdp_if.sv
// valid/ready channel interfaces of the rgb565 downsample packer
interface rdp_req_if;
   logic                         valid;
   logic                         ready;
   logic [rdp_pkg::PIXEL_W-1:0]  pixel_rgb565;
   logic                         frame_start;

   modport source (output valid, output pixel_rgb565, output frame_start, input ready);
   modport sink (input valid, input pixel_rgb565, input frame_start, output ready);
endinterface

interface rdp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rdp_pkg::BYTE_W-1:0]   packed_byte;
   logic                         frame_last;

   modport source (output valid, output packed_byte, output frame_last, input ready);
   modport sink (input valid, input packed_byte, input frame_last, output ready);
endinterface

interface rdp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [rdp_pkg::CFG_W-1:0]    display_target;

   modport source (output valid, output display_target, input ready);
   modport sink (input valid, input display_target, output ready);
endinterface

### hw/rtl/rdp_core.sv
// frame counters, pixel pick, gray conversion and bit packer
module rdp_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rdp_pkg::PIXEL_W-1:0]   pixel_rgb565,
   input  logic                          frame_start,
   input  logic [rdp_pkg::CFG_W-1:0]     display_target,
   output logic                          out_push,
   output rdp_pkg::rsp_item_type         out_item
);

   logic [rdp_pkg::SRC_COL_W-1:0] src_col_ff, src_col_in, c_src_col;
   logic [rdp_pkg::SRC_ROW_W-1:0] src_row_ff, src_row_in, c_src_row;
   logic [rdp_pkg::DST_COL_W-1:0] dst_col_ff, dst_col_in, c_dst_col;
   logic [rdp_pkg::DST_ROW_W-1:0] dst_row_ff, dst_row_in, c_dst_row;
   logic [rdp_pkg::SRC_COL_W-1:0] col_pick_ff, col_pick_in, c_col_pick;
   logic [rdp_pkg::SRC_ROW_W-1:0] row_pick_ff, row_pick_in, c_row_pick;
   logic [rdp_pkg::BYTE_W-1:0]    shift_ff, shift_in, c_shift;
   logic [rdp_pkg::CNT_W-1:0]     count_ff, count_in, c_count;
   logic                          done_ff, done_in, c_done;

   logic                          mono, gray2, enabled;
   logic [7:0]                    dw, dh;
   logic [3:0]                    ppb;
   logic [9:0]                    gray_sum;
   logic [7:0]                    gray;
   logic [rdp_pkg::BYTE_W-1:0]    shift_new;
   logic [3:0]                    count_inc;
   logic                          row_picked, pick, emit, last;
   logic [rdp_pkg::DST_COL_W-1:0] dst_col_inc;
   logic [7:0]                    row_inc;
   logic [16:0]                   col_prod_mono;
   logic [29:0]                   col_prod_gray;
   logic [15:0]                   row_prod;
   logic [rdp_pkg::SRC_COL_W-1:0] col_pick_calc;
   logic [rdp_pkg::SRC_ROW_W-1:0] row_pick_calc;
   logic                          col_end, row_end;

   always_comb begin
      mono  = 1'b0;
      gray2 = 1'b0;
      case (display_target)
         rdp_pkg::TARGET_MONO:  mono  = 1'b1;
         rdp_pkg::TARGET_GRAY2: gray2 = 1'b1;
         default: ;
      endcase
   end

   assign enabled = mono | gray2;
   assign dw  = mono ? 8'(rdp_pkg::MONO_DW)  : 8'(rdp_pkg::GRAY2_DW);
   assign dh  = mono ? 8'(rdp_pkg::MONO_DH)  : 8'(rdp_pkg::GRAY2_DH);
   assign ppb = mono ? 4'(rdp_pkg::MONO_PPB) : 4'(rdp_pkg::GRAY2_PPB);

   // frame start clears the frame state before this pixel
   assign c_src_col  = frame_start ? '0 : src_col_ff;
   assign c_src_row  = frame_start ? '0 : src_row_ff;
   assign c_dst_col  = frame_start ? '0 : dst_col_ff;
   assign c_dst_row  = frame_start ? '0 : dst_row_ff;
   assign c_col_pick = frame_start ? '0 : col_pick_ff;
   assign c_row_pick = frame_start ? '0 : row_pick_ff;
   assign c_shift    = frame_start ? '0 : shift_ff;
   assign c_count    = frame_start ? '0 : count_ff;
   assign c_done     = frame_start ? 1'b0 : done_ff;

   // gray = (r<<3 + 2*(g<<2) + b<<3) >> 2
   assign gray_sum = {2'b00, pixel_rgb565[15:11], 3'b000}
                   + {1'b0, pixel_rgb565[10:5], 3'b000}
                   + {2'b00, pixel_rgb565[4:0], 3'b000};
   assign gray = gray_sum[9:2];

   assign shift_new = mono ? {c_shift[6:0], (gray > rdp_pkg::MONO_THRESHOLD)}
                           : {c_shift[5:0], gray[7:6]};
   assign count_inc = {1'b0, c_count} + 4'd1;

   assign row_picked = enabled && !c_done && (c_src_row == c_row_pick);
   assign pick = row_picked && (c_dst_col < dw) && (c_src_col == c_col_pick);
   assign emit = pick && (count_inc >= ppb);
   assign last = (c_dst_col == dw - 8'd1) && ({1'b0, c_dst_row} == dh - 8'd1);

   assign dst_col_inc   = c_dst_col + 8'd1;
   assign col_prod_mono = 17'(dst_col_inc) * 17'(rdp_pkg::SRC_WIDTH);
   assign col_prod_gray = 30'(dst_col_inc) * 30'(rdp_pkg::COL_RECIP);
   assign col_pick_calc = mono ? col_prod_mono[rdp_pkg::MONO_COL_SHIFT +: rdp_pkg::SRC_COL_W]
                               : col_prod_gray[rdp_pkg::COL_RECIP_SHIFT +: rdp_pkg::SRC_COL_W];

   assign row_inc       = {1'b0, c_dst_row} + 8'd1;
   assign row_prod      = 16'(row_inc) * 16'(rdp_pkg::SRC_HEIGHT);
   assign row_pick_calc = mono ? row_prod[rdp_pkg::MONO_ROW_SHIFT +: rdp_pkg::SRC_ROW_W]
                               : row_prod[rdp_pkg::GRAY2_ROW_SHIFT +: rdp_pkg::SRC_ROW_W];

   assign col_end = ({1'b0, c_src_col} + 10'd1) >= 10'(rdp_pkg::SRC_WIDTH);
   assign row_end = ({1'b0, c_src_row} + 9'd1) >= 9'(rdp_pkg::SRC_HEIGHT);

   always_comb begin
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      dst_col_in  = dst_col_ff;
      dst_row_in  = dst_row_ff;
      col_pick_in = col_pick_ff;
      row_pick_in = row_pick_ff;
      shift_in    = shift_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      if (in_valid) begin
         src_col_in  = c_src_col;
         src_row_in  = c_src_row;
         dst_col_in  = c_dst_col;
         dst_row_in  = c_dst_row;
         col_pick_in = c_col_pick;
         row_pick_in = c_row_pick;
         shift_in    = c_shift;
         count_in    = c_count;
         done_in     = c_done;
         if (pick) begin
            if (emit) begin
               shift_in = '0;
               count_in = '0;
            end else begin
               shift_in = shift_new;
               count_in = count_inc[rdp_pkg::CNT_W-1:0];
            end
            dst_col_in = dst_col_inc;
            if (dst_col_inc < dw) begin
               col_pick_in = col_pick_calc;
            end
         end
         if (col_end) begin
            src_col_in = '0;
            if (row_picked) begin
               if (row_inc >= dh) begin
                  done_in = 1'b1;
               end else begin
                  dst_row_in  = row_inc[rdp_pkg::DST_ROW_W-1:0];
                  row_pick_in = row_pick_calc;
               end
            end
            dst_col_in  = '0;
            col_pick_in = '0;
            if (row_end) begin
               src_row_in  = '0;
               dst_row_in  = '0;
               row_pick_in = '0;
               shift_in    = '0;
               count_in    = '0;
               done_in     = 1'b0;
            end else begin
               src_row_in = c_src_row + 8'd1;
            end
         end else begin
            src_col_in = c_src_col + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         dst_col_ff  <= '0;
         dst_row_ff  <= '0;
         col_pick_ff <= '0;
         row_pick_ff <= '0;
         shift_ff    <= '0;
         count_ff    <= '0;
         done_ff     <= 1'b0;
      end else begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         dst_col_ff  <= dst_col_in;
         dst_row_ff  <= dst_row_in;
         col_pick_ff <= col_pick_in;
         row_pick_ff <= row_pick_in;
         shift_ff    <= shift_in;
         count_ff    <= count_in;
         done_ff     <= done_in;
      end
   end

   assign out_push              = in_valid && emit;
   assign out_item.packed_byte  = shift_new;
   assign out_item.frame_last   = last;

endmodule

### hw/rtl/rdp_skid.sv
// three-entry result queue in front of the response channel
module rdp_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rdp_pkg::rsp_item_type  push_item,
   input  logic                   pop,
   output logic                   out_valid,
   output rdp_pkg::rsp_item_type  out_item,
   output logic [1:0]             count
);

   rdp_pkg::rsp_item_type entry_ff [3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign do_pop = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == 2'd2) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'd2) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### hw/rtl/rgb565_downsample_pack.sv
// top level of the rgb565 downsample packer
// req_bus carries one rgb565 source pixel per beat in raster order, with
// frame_start on the first pixel of a frame. rsp_bus carries one packed
// display byte per beat, first pixel in the high bits, frame_last on the
// final byte of the destination frame. csr_bus writes display_target:
// 1 gives 128x64 at one bit per pixel, 2 gives 240x128 at two bits, any
// other value emits nothing. csr_bus is always ready; write it only while
// the block is idle.
// A pixel beat is registered at its accept edge, processed in the next
// cycle and its byte, if any, enters a three-entry result queue; the byte
// is offered on rsp_bus from the queue head. Throughput is one pixel per
// cycle while req_bus.ready stays high, set by the single-pass datapath.
// When the receiver stalls, the queue absorbs results and req_bus.ready
// drops once queued bytes plus the pixel in flight reach three.
// Reset clears all counters and the packer, empties the queue and sets
// display_target to 1.
module rgb565_downsample_pack (
   input  logic     clock,
   input  logic     reset,
   rdp_req_if.sink  req_bus,
   rdp_rsp_if.source rsp_bus,
   rdp_csr_if.sink  csr_bus
);

   `include "rgb565_downsample_pack_macros.svh"

   logic [rdp_pkg::CFG_W-1:0]   target_ff, target_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic [rdp_pkg::PIXEL_W-1:0] s1_pixel_ff;
   logic                        s1_start_ff;
   logic                        accept;
   logic                        push;
   rdp_pkg::rsp_item_type       push_item;
   rdp_pkg::rsp_item_type       head_item;
   logic                        head_valid;
   logic [1:0]                  queue_count;

   assign csr_bus.ready = 1'b1;
   assign target_in = (csr_bus.valid) ? csr_bus.display_target : target_ff;

   assign req_bus.ready = ({1'b0, queue_count} + {2'b00, s1_valid_ff}) <= 3'd2;
   assign accept        = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= rdp_pkg::TARGET_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         target_ff   <= target_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_bus.pixel_rgb565;
         s1_start_ff <= req_bus.frame_start;
      end
   end

   rdp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s1_valid_ff),
      .pixel_rgb565   (s1_pixel_ff),
      .frame_start    (s1_start_ff),
      .display_target (target_ff),
      .out_push       (push),
      .out_item       (push_item)
   );

   rdp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (rsp_bus.ready),
      .out_valid (head_valid),
      .out_item  (head_item),
      .count     (queue_count)
   );

   assign rsp_bus.valid       = head_valid;
   assign rsp_bus.packed_byte = head_item.packed_byte;
   assign rsp_bus.frame_last  = head_item.frame_last;

   `RDP_ASSERT_SAME(a_full_no_flight, clock, reset, (queue_count == 2'd3), !s1_valid_ff, "queue full with a pixel in flight")
   `RDP_ASSERT_SAME(a_disabled_silent, clock, reset, (target_ff != rdp_pkg::TARGET_MONO) && (target_ff != rdp_pkg::TARGET_GRAY2), !push, "byte produced while output disabled")
   `RDP_ASSERT_NEXT(a_push_queued, clock, reset, push, rsp_bus.valid, "pushed byte not offered")

endmodule

### bench/tb.sv
// testbench for rgb565_downsample_pack: directed rows, random short frames and a row crossing
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdp_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_PIXELS = 120;
   localparam int N_PHASES = 8;
   localparam int N_DIR = 30;
   localparam int MAX_PRINTED = 50;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
   typedef enum logic {ROW_PIXEL, ROW_TARGET} row_kind_e;

   typedef struct packed {
      row_kind_e   kind;
      logic [7:0]  target;
      logic [15:0] pixel;
      logic        start;
      logic        typed;
      logic [7:0]  exp_byte;
      logic        exp_last;
   } stim_row_t;

   typedef struct {
      logic [SRC_COL_W-1:0] src_col;
      logic [SRC_ROW_W-1:0] src_row;
      logic [DST_COL_W-1:0] dst_col;
      logic [DST_ROW_W-1:0] dst_row;
      logic [SRC_COL_W-1:0] col_pick;
      logic [SRC_ROW_W-1:0] row_pick;
      logic [BYTE_W-1:0]    shreg;
      logic [CNT_W-1:0]     nbits;
      bit                   done;
   } raster_state_t;

   logic clock;
   logic reset;

   rdp_req_if req_bus ();
   rdp_rsp_if rsp_bus ();
   rdp_csr_if csr_bus ();

   rgb565_downsample_pack dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // typed expectation travels with the pixel beat it belongs to
   logic         row_typed;
   rsp_item_type row_exp;

   raster_state_t raster;
   logic [CFG_W-1:0] pred_target;
   rsp_item_type pending [$];

   int send_idle_pct;
   int recv_stall_pct;
   int n_errors;
   int n_pixels;
   int n_bytes;
   int n_last;
   int n_writes;
   int quiet_cycles;

   // mono picks 0,2,5,7,10,12,15,17 give 1,0,0,1,0,0,1,1; gray2 picks 0,1,2,4 give 3,2,1,0
   stim_row_t dir_rows [N_DIR] = '{
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFC20, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFC40, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hF800, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h07E0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b1, 8'h93, 1'b0},
      '{ROW_TARGET, TARGET_GRAY2, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFC40, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h07E0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'h0000, 1'b0, 1'b1, 8'hE4, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_TARGET, 8'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_TARGET, 8'hFF,  16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_PIXEL,  8'd0,   16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_TARGET, TARGET_MONO, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0}
   };

   function automatic void clear_raster();
      raster.src_col  = '0;
      raster.src_row  = '0;
      raster.dst_col  = '0;
      raster.dst_row  = '0;
      raster.col_pick = '0;
      raster.row_pick = '0;
      raster.shreg    = '0;
      raster.nbits    = '0;
      raster.done     = 1'b0;
   endfunction

   // one source pixel through the downscaler and packer, returns 1 when a byte completes
   function automatic bit downscale_step(input logic [15:0] pix, input logic start,
                                         output rsp_item_type res);
      int dw, dh, bpp, ppb;
      int r, g, b, gray, lvl, cnt, nr;
      bit row_hit;
      bit emit;
      emit = 1'b0;
      res = '0;
      dw = 0;
      dh = 0;
      bpp = 0;
      ppb = 0;
      if (start) clear_raster();
      if (pred_target == TARGET_MONO) begin
         dw = MONO_DW; dh = MONO_DH; bpp = 1; ppb = MONO_PPB;
      end else if (pred_target == TARGET_GRAY2) begin
         dw = GRAY2_DW; dh = GRAY2_DH; bpp = 2; ppb = GRAY2_PPB;
      end
      row_hit = (bpp != 0) && !raster.done && (raster.src_row == raster.row_pick);
      if (row_hit && int'(raster.dst_col) < dw && raster.src_col == raster.col_pick) begin
         r = int'(pix[15:11]) << 3;
         g = int'(pix[10:5]) << 2;
         b = int'(pix[4:0]) << 3;
         gray = (r + g + g + b) >> 2;
         lvl = (bpp == 1) ? int'(gray > int'(MONO_THRESHOLD)) : (gray >> 6);
         cnt = int'(raster.nbits) + 1;
         raster.shreg = 8'((int'(raster.shreg) << bpp) | lvl);
         if (cnt >= ppb) begin
            res.packed_byte = raster.shreg;
            res.frame_last = (int'(raster.dst_col) == dw - 1) && (int'(raster.dst_row) == dh - 1);
            emit = 1'b1;
            raster.shreg = '0;
            raster.nbits = '0;
         end else begin
            raster.nbits = 3'(cnt);
         end
         raster.dst_col = raster.dst_col + 8'd1;
         if (int'(raster.dst_col) < dw)
            raster.col_pick = 9'(int'(raster.dst_col) * SRC_WIDTH / dw);
      end
      if (int'(raster.src_col) + 1 >= SRC_WIDTH) begin
         raster.src_col = '0;
         if (row_hit) begin
            nr = int'(raster.dst_row) + 1;
            if (nr >= dh) begin
               raster.done = 1'b1;
            end else begin
               raster.dst_row = 7'(nr);
               raster.row_pick = 8'(nr * SRC_HEIGHT / dh);
            end
         end
         raster.dst_col = '0;
         raster.col_pick = '0;
         if (int'(raster.src_row) + 1 >= SRC_HEIGHT) clear_raster();
         else raster.src_row = raster.src_row + 8'd1;
      end else begin
         raster.src_col = raster.src_col + 9'd1;
      end
      return emit;
   endfunction

   task automatic report_mismatch(input string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic set_idling(input idle_mode_e mode);
      send_idle_pct = (mode == IDLE_SEND) ? 71 : (mode == IDLE_BOTH) ? 38 : 0;
      recv_stall_pct = (mode == IDLE_RECV) ? 71 : (mode == IDLE_BOTH) ? 38 : 0;
   endtask

   task automatic send_pixel(input logic [15:0] pix, input logic start, input logic typed,
                             input rsp_item_type exp);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_rgb565 <= pix;
      req_bus.frame_start <= start;
      row_typed <= typed;
      row_exp <= exp;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold the sender until every byte is back and the pipeline is empty
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [CFG_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.display_target <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic stream_frame(input int count, input bit first_start);
      for (int k = 0; k < count; k++)
         send_pixel(16'($urandom), first_start && k == 0, 1'b0, '0);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_item_type res;
      rsp_item_type want;
      bit made;
      bit moved;
      if (reset) begin
         pred_target = TARGET_RESET;
         clear_raster();
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_bus.valid && csr_bus.ready) begin
            pred_target = csr_bus.display_target;
            n_writes++;
            moved = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            made = downscale_step(req_bus.pixel_rgb565, req_bus.frame_start, res);
            if (row_typed) pending.push_back(row_exp);
            else if (made) pending.push_back(res);
            n_pixels++;
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            n_bytes++;
            moved = 1'b1;
            if (pending.size() == 0) begin
               report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                         rsp_bus.packed_byte, rsp_bus.frame_last));
            end else begin
               want = pending.pop_front();
               if (rsp_bus.packed_byte !== want.packed_byte)
                  report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                            rsp_bus.packed_byte, want.packed_byte));
               if (rsp_bus.frame_last !== want.frame_last)
                  report_mismatch($sformatf("frame_last %0b, expected %0b",
                                            rsp_bus.frame_last, want.frame_last));
               if (want.frame_last) n_last++;
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d bytes outstanding",
                     quiet_cycles, pending.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] phase_targets [N_PHASES];
      int frame_left;
      logic start;
      n_errors = 0;
      n_pixels = 0;
      n_bytes = 0;
      n_last = 0;
      n_writes = 0;
      frame_left = 0;
      set_idling(IDLE_NONE);
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.pixel_rgb565 <= '0;
      req_bus.frame_start <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.display_target <= '0;
      row_typed <= 1'b0;
      row_exp <= '0;
      phase_targets = '{TARGET_GRAY2, TARGET_MONO, 8'd0, TARGET_GRAY2, TARGET_MONO, 8'hFF,
                        8'($urandom_range(3, 254)), TARGET_GRAY2};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_TARGET) begin
            settle_block();
            write_target(dir_rows[i].target);
         end else begin
            send_pixel(dir_rows[i].pixel, dir_rows[i].start, dir_rows[i].typed,
                       {dir_rows[i].exp_byte, dir_rows[i].exp_last});
         end
      end

      // short frames, mode switched mid-frame at each phase boundary
      for (int ph = 0; ph < N_PHASES; ph++) begin
         settle_block();
         write_target(phase_targets[ph]);
         set_idling(idle_mode_e'(ph % 4));
         for (int k = 0; k < PHASE_PIXELS; k++) begin
            if (frame_left == 0) begin
               frame_left = $urandom_range(1, 700);
               start = 1'b1;
            end else begin
               start = ($urandom_range(0, 99) < 2);
            end
            frame_left--;
            send_pixel(16'($urandom), start, 1'b0, '0);
         end
      end

      // mono frame streamed past the end of the first source row
      settle_block();
      write_target(TARGET_MONO);
      set_idling(IDLE_NONE);
      stream_frame(SRC_WIDTH + 40, 1'b1);
      settle_block();

      $display("run covered %0d pixels: directed rows, %0d short-frame phases, one row crossing",
               n_pixels, N_PHASES);
      $display("%0d bytes compared, %0d end-of-frame bytes, %0d target writes",
               n_bytes, n_last, n_writes);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rdp_pkg.sv
hw/rtl/rdp_if.sv
hw/rtl/rdp_core.sv
hw/rtl/rdp_skid.sv
hw/rtl/rgb565_downsample_pack.sv
bench/tb.sv
